>>> hdl/dense_mlp_forward_top_macros.svh
// ----------------------------------------------------------------------------
// dense_mlp_forward_top_macros.svh
// Assertion helpers shared by the engine RTL.
// ----------------------------------------------------------------------------
`ifndef DENSE_MLP_FORWARD_TOP_MACROS_SVH
`define DENSE_MLP_FORWARD_TOP_MACROS_SVH

// same-cycle implication
`define DMF_ASSERT_NOW(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define DMF_ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

>>> hdl/dmf_pkg.sv
// ----------------------------------------------------------------------------
// dmf_pkg
// Shared constants and types of the dense MLP engine.
// ----------------------------------------------------------------------------
package dmf_pkg;

	localparam int MAX_LAYERS_D  = 4;
	localparam int MAX_DIM_D     = 64;
	localparam int PARAM_DEPTH_D = 32768;
	localparam int FRAC_BITS_D   = 12;

	// parameter pointer width, wide enough for every blob layout in range
	localparam int PTR_W  = 24;
	localparam int CFG_AW = 5;
	localparam int CFG_W  = 7;

	localparam logic [2:0] REG_NUM_LAYERS = 3'd0;
	localparam logic [2:0] REG_RELU_MASK  = 3'd1;
	localparam logic [2:0] REG_INPUT_W    = 3'd2;
	localparam logic [2:0] REG_W_L1       = 3'd3;
	localparam logic [2:0] REG_W_L2       = 3'd4;
	localparam logic [2:0] REG_W_L3       = 3'd5;
	localparam logic [2:0] REG_W_L4       = 3'd6;

	typedef struct packed {
		logic rot;    // rotate x toward cell 0
		logic tail;   // this cell takes the wrap value on rotate
		logic ld_x;   // load x from the shared data bus
		logic wr_y;   // load y from the shared data bus
		logic swap;   // x <= y (layer boundary)
	} cell_ctl_t;

endpackage

>>> hdl/dense_mlp_forward_top.sv
// Parameter writes and input words are accepted only while the engine is idle.
// A pass starts after the last input word; each layer output takes in_w + 1
// reads of the parameter memory port (weights, then bias), a drain of the two
// MAC stages and a finish state, after a setup state per layer and a swap state
// between layers; all outputs go through the single MAC.
// Reset initialises control and config state; memories and cells stay undefined.
// ----------------------------------------------------------------------------
// dense_mlp_forward_top
// Dense MLP inference engine: parameter memory, activation cell chain, MAC.
// ----------------------------------------------------------------------------
module dense_mlp_forward_top #(
	parameter int MAX_LAYERS  = dmf_pkg::MAX_LAYERS_D,
	parameter int MAX_DIM     = dmf_pkg::MAX_DIM_D,
	parameter int PARAM_DEPTH = dmf_pkg::PARAM_DEPTH_D,
	parameter int FRAC_BITS   = dmf_pkg::FRAC_BITS_D
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [dmf_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // param_addr[14:0], value[30:15], zero
	input  logic        s_axis_tuser,   // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // out_value[15:0], out_index[21:16], zero
	output logic        m_axis_tlast,
	output logic        m_axis_tuser    // saturated
);
	import dmf_pkg::*;
	`include "dense_mlp_forward_top_macros.svh"

	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int PW = $clog2(PARAM_DEPTH);
	localparam int LW = 3;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LAYER = 3'd1;
	localparam logic [2:0] ST_ISSUE = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;
	localparam logic [2:0] ST_SWAP  = 3'd5;

	function automatic logic [DW-1:0] eff_w(input logic [CFG_W-1:0] w);
		if (w == '0) begin
			return DW'(1);
		end else if (32'(w) > MAX_DIM) begin
			return DW'(MAX_DIM);
		end else begin
			return DW'(w);
		end
	endfunction

	// configuration
	logic [2:0]       num_layers_q;
	logic [3:0]       relu_mask_q;
	logic [CFG_W-1:0] input_w_q;
	logic [CFG_W-1:0] lw_q [4];
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_layers_q <= 3'd1;
			relu_mask_q  <= '0;
			input_w_q    <= CFG_W'(64);
			for (int k = 0; k < 4; k++) lw_q[k] <= CFG_W'(64);
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_NUM_LAYERS: num_layers_q <= pwdata[2:0];
				REG_RELU_MASK:  relu_mask_q  <= pwdata[3:0];
				REG_INPUT_W:    input_w_q    <= pwdata[CFG_W-1:0];
				REG_W_L1:       lw_q[0]      <= pwdata[CFG_W-1:0];
				REG_W_L2:       lw_q[1]      <= pwdata[CFG_W-1:0];
				REG_W_L3:       lw_q[2]      <= pwdata[CFG_W-1:0];
				REG_W_L4:       lw_q[3]      <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_NUM_LAYERS: prdata = 32'(num_layers_q);
			REG_RELU_MASK:  prdata = 32'(relu_mask_q);
			REG_INPUT_W:    prdata = 32'(input_w_q);
			REG_W_L1:       prdata = 32'(lw_q[0]);
			REG_W_L2:       prdata = 32'(lw_q[1]);
			REG_W_L3:       prdata = 32'(lw_q[2]);
			REG_W_L4:       prdata = 32'(lw_q[3]);
			default:        prdata = '0;
		endcase
	end

	logic [LW-1:0] eff_layers;
	logic [DW-1:0] eff_in;

	always_comb begin
		eff_layers = (num_layers_q == '0) ? LW'(1) : num_layers_q;
		if (32'(eff_layers) > MAX_LAYERS) eff_layers = LW'(MAX_LAYERS);
		if (eff_layers > LW'(4)) eff_layers = LW'(4);
		eff_in = eff_w(input_w_q);
	end

	// control
	logic [2:0]       state_q;
	logic [DW-1:0]    cnt_q;
	logic [1:0]       layer_q;
	logic [DW-1:0]    inw_q;
	logic [DW-1:0]    outw_q;
	logic [DW-1:0]    o_q;
	logic [DW-1:0]    i_q;
	logic [PTR_W-1:0] base_q;
	logic [PTR_W-1:0] rowp_q;
	logic [PTR_W-1:0] biasb_q;
	logic             drain_q;
	logic             sat_q;
	logic             m_valid_q;
	logic [15:0]      m_value_q;
	logic [5:0]       m_index_q;
	logic             m_last_q;
	logic             m_sat_q;

	logic             in_acc;
	logic             elem;
	logic             pass_go;
	logic             final_l;
	logic             fin_go;
	logic             last_o;
	logic [15:0]      mac_res;
	logic             mac_clip;
	logic             sat_nx;
	logic [DW-1:0]    nxt_outw;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign elem    = in_acc && s_axis_tuser;
	assign pass_go = ({1'b0, cnt_q} + 1'b1) >= {1'b0, eff_in};
	assign final_l = ({1'b0, layer_q} + 1'b1) == eff_layers;
	assign last_o  = (o_q == outw_q - 1'b1);
	assign fin_go  = (state_q == ST_FIN) && !(final_l && m_valid_q && !m_axis_tready);
	assign sat_nx  = sat_q | mac_clip;
	assign nxt_outw = eff_w(lw_q[layer_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			layer_q   <= '0;
			inw_q     <= DW'(1);
			outw_q    <= DW'(1);
			o_q       <= '0;
			i_q       <= '0;
			base_q    <= '0;
			rowp_q    <= '0;
			biasb_q   <= '0;
			drain_q   <= 1'b0;
			sat_q     <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			m_valid_q <= (fin_go && final_l) || (m_valid_q && !m_axis_tready);
			case (state_q)
				ST_IDLE: begin
					if (elem) begin
						if (pass_go) begin
							cnt_q   <= '0;
							sat_q   <= 1'b0;
							layer_q <= '0;
							inw_q   <= eff_in;
							base_q  <= '0;
							state_q <= ST_LAYER;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_LAYER: begin
					outw_q  <= nxt_outw;
					biasb_q <= base_q + PTR_W'(nxt_outw) * PTR_W'(inw_q);
					rowp_q  <= base_q;
					o_q     <= '0;
					i_q     <= '0;
					state_q <= ST_ISSUE;
				end
				ST_ISSUE: begin
					if (i_q == inw_q) begin
						rowp_q  <= rowp_q + PTR_W'(inw_q);
						drain_q <= 1'b0;
						state_q <= ST_DRAIN;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						sat_q <= sat_nx;
						if (last_o) begin
							state_q <= final_l ? ST_IDLE : ST_SWAP;
						end else begin
							o_q     <= o_q + 1'b1;
							i_q     <= '0;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_SWAP: begin
					base_q  <= biasb_q + PTR_W'(outw_q);
					inw_q   <= outw_q;
					layer_q <= layer_q + 1'b1;
					state_q <= ST_LAYER;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go && final_l) begin
			m_value_q <= mac_res;
			m_index_q <= 6'(o_q);
			m_last_q  <= last_o;
			m_sat_q   <= sat_nx;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, m_index_q, m_value_q};
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tuser  = m_sat_q;

	// parameter memory, one port
	logic [15:0]      pmem [PARAM_DEPTH];
	logic [PTR_W-1:0] waddr;
	logic [PTR_W-1:0] raddr;
	logic             pwr;
	logic             issue;
	logic             rd_ok;
	logic [15:0]      rdata_s1;
	logic             vld_s1;
	logic             bias_s1;
	logic             ok_s1;

	assign waddr = PTR_W'(s_axis_tdata[14:0]);
	assign pwr   = in_acc && !s_axis_tuser && (32'(waddr) < PARAM_DEPTH);
	assign issue = (state_q == ST_ISSUE);
	assign raddr = (i_q == inw_q) ? biasb_q + PTR_W'(o_q) : rowp_q + PTR_W'(i_q);
	assign rd_ok = 32'(raddr) < PARAM_DEPTH;

	always_ff @(posedge clk) begin
		if (pwr) begin
			pmem[waddr[PW-1:0]] <= s_axis_tdata[30:15];
		end else begin
			rdata_s1 <= pmem[raddr[PW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			bias_s1 <= 1'b0;
			ok_s1   <= 1'b0;
		end else begin
			vld_s1  <= issue;
			bias_s1 <= issue && (i_q == inw_q);
			ok_s1   <= rd_ok;
		end
	end

	// activation cell chain
	logic [15:0] cx [MAX_DIM];
	logic [15:0] cy [MAX_DIM];
	logic [15:0] din;
	logic        rot;

	assign din = (state_q == ST_IDLE) ? s_axis_tdata[30:15] : mac_res;
	assign rot = vld_s1 && !bias_s1;

	for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
		cell_ctl_t    ctl;
		logic [15:0] nb;

		assign ctl.rot  = rot;
		assign ctl.tail = (DW'(k) == inw_q - 1'b1);
		assign ctl.ld_x = elem && (cnt_q == DW'(k));
		assign ctl.wr_y = fin_go && (o_q == DW'(k));
		assign ctl.swap = (state_q == ST_SWAP);
		assign nb = (k == MAX_DIM - 1) ? 16'h0000 : cx[(k + 1) % MAX_DIM];

		dmf_cell u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.din    (din),
			.nb_x   (nb),
			.wrap_x (cx[0]),
			.x      (cx[k]),
			.y      (cy[k])
		);
	end

	dmf_mac #(
		.MAX_DIM   (MAX_DIM),
		.FRAC_BITS (FRAC_BITS)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s1  (vld_s1),
		.bias_s1 (bias_s1),
		.w_s1    (ok_s1 ? rdata_s1 : 16'h0000),
		.x_s1    (cx[0]),
		.clr     (fin_go || (state_q == ST_LAYER)),
		.relu    (relu_mask_q[layer_q]),
		.res     (mac_res),
		.clip    (mac_clip)
	);

	`DMF_ASSERT_NOW(a_fin_drained, clk, arst_n, state_q == ST_FIN, !vld_s1, "MAC busy at finish")
	`DMF_ASSERT_NOW(a_rd_from_issue, clk, arst_n, vld_s1, $past(state_q == ST_ISSUE), "stray read")
	`DMF_ASSERT_NOW(a_out_from_fin, clk, arst_n, $rose(m_valid_q), $past(state_q == ST_FIN), "stray output")
	`DMF_ASSERT_NXT(a_swap_to_layer, clk, arst_n, state_q == ST_SWAP, state_q == ST_LAYER, "bad swap")

endmodule

>>> hdl/dmf_cell.sv
// ----------------------------------------------------------------------------
// dmf_cell
// One activation cell: holds a source element (x) and a result element (y).
// ----------------------------------------------------------------------------
module dmf_cell (
	input  logic              clk,
	input  dmf_pkg::cell_ctl_t ctl,
	input  logic [15:0]       din,
	input  logic [15:0]       nb_x,
	input  logic [15:0]       wrap_x,
	output logic [15:0]       x,
	output logic [15:0]       y
);
	import dmf_pkg::*;

	logic [15:0] x_q;
	logic [15:0] y_q;

	always_ff @(posedge clk) begin
		if (ctl.swap) begin
			x_q <= y_q;
		end else if (ctl.ld_x) begin
			x_q <= din;
		end else if (ctl.rot) begin
			x_q <= ctl.tail ? wrap_x : nb_x;
		end
		if (ctl.wr_y) begin
			y_q <= din;
		end
	end

	assign x = x_q;
	assign y = y_q;

endmodule

>>> hdl/dmf_mac.sv
// ----------------------------------------------------------------------------
// dmf_mac
// Multiply-accumulate unit with round, saturate and ReLU on the result.
// ----------------------------------------------------------------------------
module dmf_mac #(
	parameter int MAX_DIM   = dmf_pkg::MAX_DIM_D,
	parameter int FRAC_BITS = dmf_pkg::FRAC_BITS_D
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld_s1,
	input  logic               bias_s1,
	input  logic signed [15:0] w_s1,
	input  logic signed [15:0] x_s1,
	input  logic               clr,
	input  logic               relu,
	output logic [15:0]        res,
	output logic               clip
);
	import dmf_pkg::*;

	localparam int ACC_W = 34 + $clog2(MAX_DIM + 1);
	localparam logic signed [ACC_W-1:0] HALF =
		(FRAC_BITS > 0) ? (ACC_W'(1) << (FRAC_BITS - 1)) : '0;
	localparam logic signed [ACC_W-1:0] SMAX = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SMIN = -ACC_W'(32768);

	logic signed [ACC_W-1:0] p_s2;
	logic                    vld_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [31:0]      prod;
	logic signed [ACC_W-1:0] rnd;
	logic signed [ACC_W-1:0] sh;
	logic signed [15:0]      sat_v;

	assign prod = w_s1 * x_s1;

	always_ff @(posedge clk) begin
		if (bias_s1) begin
			p_s2 <= ACC_W'(w_s1) <<< FRAC_BITS;
		end else begin
			p_s2 <= ACC_W'(prod);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s2 <= vld_s1;
			if (clr) begin
				acc_q <= '0;
			end else if (vld_s2) begin
				acc_q <= acc_q + p_s2;
			end
		end
	end

	// round half up, then clip to 16 bits
	always_comb begin
		rnd = acc_q + HALF;
		sh  = rnd >>> FRAC_BITS;
		clip = 1'b0;
		if (sh > SMAX) begin
			sat_v = 16'sh7fff;
			clip  = 1'b1;
		end else if (sh < SMIN) begin
			sat_v = -16'sh8000;
			clip  = 1'b1;
		end else begin
			sat_v = sh[15:0];
		end
		if (relu && sat_v[15]) begin
			res = '0;
		end else begin
			res = sat_v;
		end
	end

endmodule
